@@ hw/rtl/arith_expression_lexer_defines.svh @@
// Assertion macros for the arithmetic expression lexer.
// Included by modules that check their own logic; expects clk and rst_n in scope.
`ifndef ARITH_EXPRESSION_LEXER_DEFINES_SVH
`define ARITH_EXPRESSION_LEXER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ALE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Check that cons holds in the cycle after ante.
`define ALE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer sequence check failed");

`endif

@@ hw/rtl/ale_pkg.sv @@
// Shared types and constants of the arithmetic expression lexer.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package ale_pkg;

    localparam int ACC_W  = 60;
    localparam int SIG_W  = 61;
    localparam int FRAC_W = 5;
    localparam int KIND_W = 4;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_CARET = 8'h5E;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_ADD      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SUBTRACT = 4'd2;
    localparam logic [KIND_W-1:0] KIND_MULTIPLY = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DIVIDE   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_POWER    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CLOSE    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_END      = 4'd8;

    localparam logic ACTION_CHAR = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [SIG_W-1:0] sig;
        logic [FRAC_W-1:0]       frac;
        logic                    ovf;
        logic                    last;
    } token_t;

    function automatic logic [ACC_W-1:0] digit_limit(input int digits);
        logic [63:0] v;
        logic [63:0] lim;
        v = 64'd1;
        for (int i = 0; i < digits; i++)
        begin
            v = v * 64'd10;
        end
        lim = v - 64'd1;
        return lim[ACC_W-1:0];
    endfunction

endpackage

@@ hw/rtl/ale_channels.sv @@
// Valid/ready channel interfaces of the arithmetic expression lexer.
// Depends on ale_pkg for field widths.
`timescale 1ns / 1ps

interface ale_char_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] character;

    modport source (output valid, output action, output character, input ready);
    modport sink (input valid, input action, input character, output ready);
endinterface

interface ale_token_if;
    logic                                      valid;
    logic                                      ready;
    logic [ale_pkg::KIND_W-1:0]                token_kind;
    logic signed [ale_pkg::SIG_W-1:0]          significand;
    logic [ale_pkg::FRAC_W-1:0]                fraction_digits;
    logic                                      digits_overflow;
    logic                                      last_of_run;

    modport source (output valid, output token_kind, output significand,
                    output fraction_digits, output digits_overflow,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input significand,
                  input fraction_digits, input digits_overflow,
                  input last_of_run, output ready);
endinterface

@@ hw/rtl/arith_expression_lexer.sv @@
// Top level of the arithmetic expression lexer: lexer state and token queue.
// Depends on ale_pkg, ale_channels.sv and arith_expression_lexer_defines.svh.
//
// channel  dir  request carries
// chars    in   action, character
// tokens   out  token_kind, significand, fraction_digits, digits_overflow, last_of_run
//
// One request per cycle while chars.ready is high; each is decoded in the cycle it is taken and its
// zero to two tokens are written to a four-entry token queue.
// chars.ready is high while the queue has at least two free entries, so a request
// yielding one token sustains one per cycle when tokens drains freely.
// Tokens are registered in the queue and never bypass it; rst_n clears mode and queue.
`timescale 1ns / 1ps

`include "arith_expression_lexer_defines.svh"

module arith_expression_lexer #(
    parameter int MAX_DIGITS = 18
) (
    input  logic              clk,
    input  logic              rst_n,
    ale_char_if.sink          chars,
    ale_token_if.source       tokens
);

    localparam int ACC_W    = ale_pkg::ACC_W;
    localparam int FRAC_W   = ale_pkg::FRAC_W;
    localparam int DEPTH    = 4;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam logic [ACC_W-1:0]  LIM      = ale_pkg::digit_limit(MAX_DIGITS);
    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0]  ROOM_MAX = CNT_W'(DEPTH - 2);

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_PLUS    = 3'd1,
        MODE_MINUS   = 3'd2,
        MODE_INT     = 3'd3,
        MODE_FRAC    = 3'd4,
        MODE_DOTFRAC = 3'd5
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [FRAC_W-1:0]    frac_reg, frac_next;
    logic                 neg_reg, neg_next;
    logic                 ovf_reg, ovf_next;

    ale_pkg::token_t      queue_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 accept;
    logic                 pop;
    logic                 is_dig;
    logic [3:0]           dval;
    logic [ACC_W+3:0]     prod;
    logic                 in_frac;
    logic                 digit_ok;
    logic                 run_idle;
    logic                 have_a, have_b;
    ale_pkg::token_t      tok_a, tok_b, num_tok;
    ale_pkg::token_t      t0, t1;
    logic [1:0]           n_push;

    assign accept       = chars.valid && chars.ready;
    assign pop          = tokens.valid && tokens.ready;
    assign chars.ready  = (count_reg <= ROOM_MAX);

    assign is_dig  = (chars.character >= ale_pkg::CHAR_ZERO) &&
                     (chars.character <= ale_pkg::CHAR_NINE);
    assign dval    = 4'(chars.character - ale_pkg::CHAR_ZERO);
    assign in_frac = (mode_reg == MODE_FRAC) || (mode_reg == MODE_DOTFRAC);
    assign prod    = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                     {{ACC_W{1'b0}}, dval};
    assign digit_ok = (prod <= {4'b0, LIM}) && (!in_frac || (frac_reg < FRAC_MAX));

    always_comb
    begin
        num_tok.kind = ale_pkg::KIND_NUMBER;
        num_tok.sig  = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
        num_tok.frac = frac_reg;
        num_tok.ovf  = ovf_reg;
        num_tok.last = 1'b0;
    end

    function automatic ale_pkg::token_t plain_tok(input logic [ale_pkg::KIND_W-1:0] kind);
        ale_pkg::token_t t;
        t      = '0;
        t.kind = kind;
        return t;
    endfunction

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        frac_next = frac_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        have_a    = 1'b0;
        have_b    = 1'b0;
        tok_a     = '0;
        tok_b     = '0;
        run_idle  = 1'b0;

        if (chars.action == ale_pkg::ACTION_END)
        begin
            unique case (mode_reg)
                MODE_PLUS:
                begin
                    have_a = 1'b1;
                    tok_a  = plain_tok(ale_pkg::KIND_ADD);
                end
                MODE_MINUS:
                begin
                    have_a = 1'b1;
                    tok_a  = plain_tok(ale_pkg::KIND_SUBTRACT);
                end
                MODE_INT, MODE_FRAC, MODE_DOTFRAC:
                begin
                    have_a = 1'b1;
                    tok_a  = num_tok;
                end
                default:
                begin
                end
            endcase
            have_b    = 1'b1;
            tok_b     = plain_tok(ale_pkg::KIND_END);
            mode_next = MODE_IDLE;
            acc_next  = '0;
            frac_next = '0;
            neg_next  = 1'b0;
            ovf_next  = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_PLUS, MODE_MINUS:
                begin
                    if (is_dig)
                    begin
                        acc_next  = ACC_W'(dval);
                        frac_next = '0;
                        neg_next  = (mode_reg == MODE_MINUS);
                        ovf_next  = 1'b0;
                        mode_next = MODE_INT;
                    end
                    else
                    begin
                        have_a   = 1'b1;
                        tok_a    = plain_tok((mode_reg == MODE_PLUS) ? ale_pkg::KIND_ADD
                                                                   : ale_pkg::KIND_SUBTRACT);
                        run_idle = 1'b1;
                    end
                end
                MODE_INT, MODE_FRAC, MODE_DOTFRAC:
                begin
                    if (is_dig)
                    begin
                        if (digit_ok)
                        begin
                            acc_next  = prod[ACC_W-1:0];
                            frac_next = in_frac ? frac_reg + 5'd1 : frac_reg;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                            acc_next = in_frac ? acc_reg : LIM;
                        end
                    end
                    else if ((mode_reg != MODE_DOTFRAC) &&
                             (chars.character == ale_pkg::CHAR_COMMA))
                    begin
                    end
                    else if ((mode_reg == MODE_INT) &&
                             (chars.character == ale_pkg::CHAR_DOT))
                    begin
                        mode_next = MODE_FRAC;
                    end
                    else
                    begin
                        have_a    = 1'b1;
                        tok_a     = num_tok;
                        acc_next  = '0;
                        frac_next = '0;
                        neg_next  = 1'b0;
                        ovf_next  = 1'b0;
                        run_idle  = 1'b1;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_idle)
            begin
                mode_next = MODE_IDLE;
                if (is_dig)
                begin
                    acc_next  = ACC_W'(dval);
                    frac_next = '0;
                    neg_next  = 1'b0;
                    ovf_next  = 1'b0;
                    mode_next = MODE_INT;
                end
                else
                begin
                    unique case (chars.character)
                        ale_pkg::CHAR_PLUS:  mode_next = MODE_PLUS;
                        ale_pkg::CHAR_MINUS: mode_next = MODE_MINUS;
                        ale_pkg::CHAR_DOT:
                        begin
                            acc_next  = '0;
                            frac_next = '0;
                            neg_next  = 1'b0;
                            ovf_next  = 1'b0;
                            mode_next = MODE_DOTFRAC;
                        end
                        ale_pkg::CHAR_STAR:
                        begin
                            have_b = 1'b1;
                            tok_b  = plain_tok(ale_pkg::KIND_MULTIPLY);
                        end
                        ale_pkg::CHAR_SLASH:
                        begin
                            have_b = 1'b1;
                            tok_b  = plain_tok(ale_pkg::KIND_DIVIDE);
                        end
                        ale_pkg::CHAR_CARET:
                        begin
                            have_b = 1'b1;
                            tok_b  = plain_tok(ale_pkg::KIND_POWER);
                        end
                        ale_pkg::CHAR_OPEN:
                        begin
                            have_b = 1'b1;
                            tok_b  = plain_tok(ale_pkg::KIND_OPEN);
                        end
                        ale_pkg::CHAR_CLOSE:
                        begin
                            have_b = 1'b1;
                            tok_b  = plain_tok(ale_pkg::KIND_CLOSE);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        n_push = 2'({1'b0, have_a} + {1'b0, have_b});
        t0     = have_a ? tok_a : tok_b;
        t1     = tok_b;
        t0.last = !(have_a && have_b);
        t1.last = 1'b1;
        if (!accept)
        begin
            n_push = 2'd0;
        end
        count_next = count_reg + CNT_W'(n_push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            acc_reg    <= '0;
            frac_reg   <= '0;
            neg_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                frac_reg <= frac_next;
                neg_reg  <= neg_next;
                ovf_reg  <= ovf_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= t0;
        end
        if (n_push == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= t1;
        end
    end

    assign tokens.valid           = (count_reg != '0);
    assign tokens.token_kind      = queue_reg[rd_ptr_reg].kind;
    assign tokens.significand     = queue_reg[rd_ptr_reg].sig;
    assign tokens.fraction_digits = queue_reg[rd_ptr_reg].frac;
    assign tokens.digits_overflow = queue_reg[rd_ptr_reg].ovf;
    assign tokens.last_of_run     = queue_reg[rd_ptr_reg].last;

    `ALE_ASSERT_IMPL(a_queue_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `ALE_ASSERT_IMPL(a_acc_limit, 1'b1, acc_reg <= LIM)
    `ALE_ASSERT_IMPL(a_frac_limit, 1'b1, frac_reg <= FRAC_MAX)
    `ALE_ASSERT_IMPL(a_idle_clear,
        (mode_reg == MODE_IDLE) || (mode_reg == MODE_PLUS) || (mode_reg == MODE_MINUS),
        (acc_reg == '0) && (frac_reg == '0) && !neg_reg && !ovf_reg)
    `ALE_ASSERT_NEXT(a_drain, pop && !accept, count_reg == $past(count_reg) - CNT_W'(1))

endmodule
